/* hdl/multitouch_slot_event_generator_macros.svh */
// ----------------------------------------------------------------------------
// multitouch slot event generator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef MULTITOUCH_SLOT_EVENT_GENERATOR_MACROS_SVH
`define MULTITOUCH_SLOT_EVENT_GENERATOR_MACROS_SVH

// same-cycle implication
`define MTSEG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MTSEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/mtseg_pkg.sv */
// ----------------------------------------------------------------------------
// mtseg_pkg
// shared constants and command type of the multitouch slot event generator
// ----------------------------------------------------------------------------
package mtseg_pkg;

  localparam int NUM_SLOTS       = 10;
  localparam int FIRST_FREE_SLOT = 2;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int COUNT_W         = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] OPC_MOVE    = 3'd0;
  localparam logic [2:0] OPC_REQUEST = 3'd1;
  localparam logic [2:0] OPC_RELEASE = 3'd2;
  localparam logic [2:0] OPC_WHEEL   = 3'd3;
  localparam logic [2:0] OPC_MOUSE   = 3'd4;

  localparam logic [SLOT_W-1:0] WHEEL_SLOT = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] MOUSE_SLOT = SLOT_W'(0);

  localparam logic [1:0] TYPE_SYN = 2'd0;
  localparam logic [1:0] TYPE_KEY = 2'd1;
  localparam logic [1:0] TYPE_ABS = 2'd3;

  localparam logic [8:0] CODE_REPORT = 9'd0;
  localparam logic [8:0] CODE_SLOT   = 9'd47;
  localparam logic [8:0] CODE_X      = 9'd53;
  localparam logic [8:0] CODE_Y      = 9'd54;
  localparam logic [8:0] CODE_TRACK  = 9'd57;
  localparam logic [8:0] CODE_TOUCH  = 9'd330;

  localparam logic [15:0] TRACK_BASE = 16'h00e2;
  localparam logic [15:0] TRACK_NONE = 16'hffff;
  localparam logic [4:0]  SLOT_NONE  = 5'h1f;

  typedef enum logic [1:0] {
    CMD_NOOP,
    CMD_MOVE,
    CMD_RELEASE,
    CMD_REQUEST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              sw;
    logic              touch;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
  } cmd_t;

endpackage

/* hdl/mtseg_front.sv */
// ----------------------------------------------------------------------------
// mtseg_front
// accepts items, allocates slots, tracks contacts and issues commands
// ----------------------------------------------------------------------------
module mtseg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          in_opcode_i,
  input  logic signed [4:0]   in_slot_i,
  input  logic signed [15:0]  in_pos_x_i,
  input  logic signed [15:0]  in_pos_y_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output mtseg_pkg::cmd_t     cmd_o
);

  logic [mtseg_pkg::NUM_SLOTS-1:0] busy_q, busy_d;
  logic [mtseg_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic                            cur_vld_q, cur_vld_d;
  logic [mtseg_pkg::SLOT_W-1:0]    cur_q, cur_d;

  logic                            slot_ok;
  logic [mtseg_pkg::SLOT_W-1:0]    slot_idx;
  logic                            free_found;
  logic [mtseg_pkg::SLOT_W-1:0]    free_idx;
  logic                            req_ok;
  logic [mtseg_pkg::SLOT_W-1:0]    req_slot;
  mtseg_pkg::cmd_t                 cmd;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign cmd_o      = cmd;

  assign slot_ok  = !in_slot_i[4] && ({1'b0, in_slot_i[3:0]} < 5'(mtseg_pkg::NUM_SLOTS));
  assign slot_idx = in_slot_i[mtseg_pkg::SLOT_W-1:0];

  // lowest free allocatable slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = mtseg_pkg::NUM_SLOTS - 1; i >= mtseg_pkg::FIRST_FREE_SLOT; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = mtseg_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = mtseg_pkg::CMD_NOOP;
    cmd.pos_x = in_pos_x_i;
    cmd.pos_y = in_pos_y_i;
    req_ok    = 1'b0;
    req_slot  = '0;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    cur_vld_d = cur_vld_q;
    cur_d     = cur_q;
    case (in_opcode_i)
      mtseg_pkg::OPC_MOVE, mtseg_pkg::OPC_RELEASE: begin
        if (slot_ok) begin
          cmd.kind  = (in_opcode_i == mtseg_pkg::OPC_MOVE) ? mtseg_pkg::CMD_MOVE
                                                          : mtseg_pkg::CMD_RELEASE;
          cmd.slot  = slot_idx;
          cmd.sw    = !(cur_vld_q && (cur_q == slot_idx));
          cur_vld_d = 1'b1;
          cur_d     = slot_idx;
          if (in_opcode_i == mtseg_pkg::OPC_RELEASE) begin
            cmd.touch        = (cnt_q == mtseg_pkg::COUNT_W'(1));
            busy_d[slot_idx] = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - mtseg_pkg::COUNT_W'(1);
            end
          end
        end
      end
      mtseg_pkg::OPC_REQUEST: begin
        req_ok   = free_found;
        req_slot = free_idx;
      end
      mtseg_pkg::OPC_WHEEL: begin
        req_ok   = 1'b1;
        req_slot = mtseg_pkg::WHEEL_SLOT;
      end
      mtseg_pkg::OPC_MOUSE: begin
        req_ok   = 1'b1;
        req_slot = mtseg_pkg::MOUSE_SLOT;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
    if (req_ok) begin
      cmd.kind         = mtseg_pkg::CMD_REQUEST;
      cmd.slot         = req_slot;
      cmd.sw           = 1'b1;
      cmd.touch        = (cnt_q == '0);
      busy_d[req_slot] = 1'b1;
      cur_vld_d        = 1'b1;
      cur_d            = req_slot;
      if (cnt_q != mtseg_pkg::COUNT_MAX) begin
        cnt_d = cnt_q + mtseg_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      cnt_q     <= '0;
      cur_vld_q <= 1'b0;
      cur_q     <= '0;
    end else if (push_o) begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      cur_vld_q <= cur_vld_d;
      cur_q     <= cur_d;
    end
  end

endmodule

/* hdl/mtseg_fifo.sv */
// ----------------------------------------------------------------------------
// mtseg_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mtseg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mtseg_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output mtseg_pkg::cmd_t cmd_o
);

  mtseg_pkg::cmd_t              mem_q [mtseg_pkg::QUEUE_DEPTH];
  logic [mtseg_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mtseg_pkg::QCNT_W-1:0] cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == mtseg_pkg::QCNT_W'(mtseg_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == mtseg_pkg::QPTR_W'(mtseg_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + mtseg_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == mtseg_pkg::QPTR_W'(mtseg_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + mtseg_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + mtseg_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - mtseg_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/mtseg_back.sv */
// ----------------------------------------------------------------------------
// mtseg_back
// steps through the records of one command, one record per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module mtseg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mtseg_pkg::cmd_t     q_cmd_i,
  output logic                q_pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_event_valid_o,
  output logic [1:0]          out_event_type_o,
  output logic [8:0]          out_event_code_o,
  output logic signed [15:0]  out_event_value_o,
  output logic signed [4:0]   out_slot_o,
  output logic                out_last_o
);

  typedef enum logic [2:0] {
    STEP_SLOT,
    STEP_TRACK,
    STEP_TOUCH,
    STEP_X,
    STEP_Y,
    STEP_SYNC,
    STEP_NOOP
  } step_e;

  typedef struct packed {
    logic        vld;
    logic [1:0]  typ;
    logic [8:0]  code;
    logic [15:0] value;
    logic [4:0]  slot;
    logic        last;
  } rec_t;

  function automatic step_e first_step(mtseg_pkg::cmd_t c);
    step_e s;
    case (c.kind)
      mtseg_pkg::CMD_MOVE:    s = c.sw ? STEP_SLOT : STEP_X;
      mtseg_pkg::CMD_RELEASE: s = c.sw ? STEP_SLOT : STEP_TRACK;
      mtseg_pkg::CMD_REQUEST: s = STEP_SLOT;
      default:                s = STEP_NOOP;
    endcase
    return s;
  endfunction

  function automatic step_e next_step(step_e cur, mtseg_pkg::cmd_t c);
    step_e s;
    case (cur)
      STEP_SLOT:  s = (c.kind == mtseg_pkg::CMD_MOVE) ? STEP_X : STEP_TRACK;
      STEP_TRACK: begin
        if (c.touch) begin
          s = STEP_TOUCH;
        end else begin
          s = (c.kind == mtseg_pkg::CMD_RELEASE) ? STEP_SYNC : STEP_X;
        end
      end
      STEP_TOUCH: s = (c.kind == mtseg_pkg::CMD_RELEASE) ? STEP_SYNC : STEP_X;
      STEP_X:     s = STEP_Y;
      STEP_Y:     s = STEP_SYNC;
      default:    s = STEP_NOOP;
    endcase
    return s;
  endfunction

  mtseg_pkg::cmd_t cmd_q;
  step_e           step_q;
  logic            active_q;
  logic            out_valid_q;
  rec_t            rec_q, rec_d;
  logic            emit, step_last, load;
  logic [4:0]      slot_ext;

  assign slot_ext  = 5'(cmd_q.slot);
  assign emit      = active_q && (!out_valid_q || out_ready_i);
  assign step_last = (step_q == STEP_SYNC) || (step_q == STEP_NOOP);
  assign load      = q_valid_i && (!active_q || (emit && step_last));
  assign q_pop_o   = load;

  always_comb begin
    rec_d       = '0;
    rec_d.vld   = 1'b1;
    rec_d.slot  = slot_ext;
    rec_d.last  = step_last;
    case (step_q)
      STEP_SLOT: begin
        rec_d.typ   = mtseg_pkg::TYPE_ABS;
        rec_d.code  = mtseg_pkg::CODE_SLOT;
        rec_d.value = 16'(cmd_q.slot);
      end
      STEP_TRACK: begin
        rec_d.typ   = mtseg_pkg::TYPE_ABS;
        rec_d.code  = mtseg_pkg::CODE_TRACK;
        rec_d.value = (cmd_q.kind == mtseg_pkg::CMD_RELEASE) ? mtseg_pkg::TRACK_NONE
                      : mtseg_pkg::TRACK_BASE + 16'(cmd_q.slot);
      end
      STEP_TOUCH: begin
        rec_d.typ   = mtseg_pkg::TYPE_KEY;
        rec_d.code  = mtseg_pkg::CODE_TOUCH;
        rec_d.value = (cmd_q.kind == mtseg_pkg::CMD_RELEASE) ? 16'd0 : 16'd1;
      end
      STEP_X: begin
        rec_d.typ   = mtseg_pkg::TYPE_ABS;
        rec_d.code  = mtseg_pkg::CODE_X;
        rec_d.value = cmd_q.pos_x;
      end
      STEP_Y: begin
        rec_d.typ   = mtseg_pkg::TYPE_ABS;
        rec_d.code  = mtseg_pkg::CODE_Y;
        rec_d.value = cmd_q.pos_y;
      end
      STEP_SYNC: begin
        rec_d.typ   = mtseg_pkg::TYPE_SYN;
        rec_d.code  = mtseg_pkg::CODE_REPORT;
      end
      default: begin
        rec_d.vld  = 1'b0;
        rec_d.slot = mtseg_pkg::SLOT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      step_q      <= STEP_NOOP;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rec_q       <= '0;
    end else begin
      if (load) begin
        cmd_q    <= q_cmd_i;
        step_q   <= first_step(q_cmd_i);
        active_q <= 1'b1;
      end else if (emit) begin
        if (step_last) begin
          active_q <= 1'b0;
        end else begin
          step_q <= next_step(step_q, cmd_q);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        rec_q       <= rec_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_event_valid_o = rec_q.vld;
  assign out_event_type_o  = rec_q.typ;
  assign out_event_code_o  = rec_q.code;
  assign out_event_value_o = rec_q.value;
  assign out_slot_o        = rec_q.slot;
  assign out_last_o        = rec_q.last;

endmodule

/* hdl/multitouch_slot_event_generator.sv */
// ----------------------------------------------------------------------------
// multitouch_slot_event_generator
// turns touch requests, moves and releases into multitouch type-b records
// ----------------------------------------------------------------------------
// Each accepted item yields one to six records on the master stream, one
// record per cycle unless m_axis_tready stalls it, the final one marked by
// tlast: a touch, wheel or mouse request yields five or six records, a move
// three or four, a release two to four, and an ignored or invalid item one
// (a single record with tuser low), as the back-end record sequencer sets them.
// Slot allocation and contact counting happen at acceptance; a two-entry
// command queue lets the input side run ahead of records being sent or stalled.
module multitouch_slot_event_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot_in[4:0], pos_x[20:5], pos_y[36:21], zero pad
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // event_type[1:0], event_code[10:2],
                                     // event_value[26:11], slot_out[31:27]
  output logic [0:0]  m_axis_tuser,  // event_valid[0]
  output logic        m_axis_tlast
);

  logic                push, q_full, q_valid, q_pop;
  mtseg_pkg::cmd_t     push_cmd, head_cmd;
  logic                ev_valid;
  logic [1:0]          ev_type;
  logic [8:0]          ev_code;
  logic signed [15:0]  ev_value;
  logic signed [4:0]   ev_slot;

  mtseg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_slot_i   (s_axis_tdata[4:0]),
    .in_pos_x_i  (s_axis_tdata[20:5]),
    .in_pos_y_i  (s_axis_tdata[36:21]),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  mtseg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  mtseg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (head_cmd),
    .q_pop_o           (q_pop),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_event_valid_o (ev_valid),
    .out_event_type_o  (ev_type),
    .out_event_code_o  (ev_code),
    .out_event_value_o (ev_value),
    .out_slot_o        (ev_slot),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {ev_slot, ev_value, ev_code, ev_type};
  assign m_axis_tuser = ev_valid;

endmodule

/* hdl/mtseg_checker.sv */
// ----------------------------------------------------------------------------
// mtseg_checker
// port-level checks of the record stream, bound to the top level
// ----------------------------------------------------------------------------
`include "multitouch_slot_event_generator_macros.svh"

module mtseg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        in_seen;
  logic        out_stall;
  logic [33:0] out_word;
  logic        out_noop;
  logic        noop_ok;
  logic        out_end;
  logic        end_ok;
  logic        out_sync;

  assign in_seen   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_noop  = m_axis_tvalid && !m_axis_tuser[0];
  assign noop_ok   = m_axis_tlast && (m_axis_tdata == {mtseg_pkg::SLOT_NONE, 27'd0});
  assign out_end   = m_axis_tvalid && m_axis_tlast;
  assign end_ok    = !m_axis_tuser[0] || (m_axis_tdata[10:0] == 11'd0);
  assign out_sync  = m_axis_tvalid && m_axis_tuser[0]
                     && (m_axis_tdata[1:0] == mtseg_pkg::TYPE_SYN);

  // stalled record holds
  `MTSEG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // a no-op record stands alone and carries no slot
  `MTSEG_ASSERT_SAME(a_noop_alone, clk_i, rst_ni, out_noop, noop_ok)

  // every run ends in a sync record or a no-op
  `MTSEG_ASSERT_SAME(a_last_is_sync, clk_i, rst_ni, out_end, end_ok)

  // a sync record always closes its run
  `MTSEG_ASSERT_SAME(a_sync_is_last, clk_i, rst_ni, out_sync, m_axis_tlast)

  // nothing comes out in the cycle after reset releases without an accepted item
  `MTSEG_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, !$past(rst_ni) && !in_seen, !m_axis_tvalid)

endmodule

bind multitouch_slot_event_generator mtseg_checker u_mtseg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
